### rtl/core/sowd_pkg.sv
// ----------------------------------------------------------------------------
// sowd_pkg
// Shared types and constants of the sort block: item and result payloads,
// the command word between front and back, the register map.
// ----------------------------------------------------------------------------
package sowd_pkg;

	localparam int VALUE_W     = 31;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register index, taken from paddr bit 2
	localparam logic REG_DESCENDING  = 1'b0;
	localparam logic REG_UNIQUE_ONLY = 1'b1;

	typedef logic [VALUE_W-1:0] value_t;

	typedef struct packed {
		value_t value;
		logic   is_last;
	} in_item_t;

	typedef struct packed {
		value_t sorted_value;
		logic   end_of_set;
		logic   overflowed;
	} out_item_t;

	typedef struct packed {
		value_t value;
		logic   store;
		logic   last;
		logic   overflowed;
	} cmd_t;

endpackage

### rtl/core/sort_with_order_and_dedupe.sv
// ----------------------------------------------------------------------------
// sort_with_order_and_dedupe
// Collects a set of values, then returns them sorted, optionally descending
// and with repeated values removed.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready/item) takes one value per transfer;
// is_last closes the set. Up to MAX_ELEMENTS values are kept, later ones are
// dropped and every result of that set then carries overflowed.
// Output channel (result_valid/result_ready/result) returns the set in order,
// end_of_set on the last result. APB registers: descending at 0x0,
// unique_only at 0x4, both read back; pready is always high.
// Values enter the insertion chain at one per cycle while the back is idle,
// through a two-entry command queue. After the last item of a set the back
// steps through align, drain and flush; when descending, align first shifts
// the chain up until its top cell is filled. The set drains at one element
// per cycle while the output register is free. Items of the next set queue
// up meanwhile and wait until the drain is done. A stalled receiver holds the
// drain; one finished result waits in the output register while the next is formed.
// Reset empties the chain and the queue and clears both registers.
// ----------------------------------------------------------------------------
module sort_with_order_and_dedupe #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  sowd_pkg::in_item_t                    item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output sowd_pkg::out_item_t                   result,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sowd_pkg::ADDR_W-1:0]           paddr,
	input  logic [sowd_pkg::DATA_W-1:0]           pwdata,
	output logic [sowd_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);
	import sowd_pkg::*;

	logic descending_q;
	logic unique_only_q;
	logic reg_wr;
	logic rd_bit;

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	assign pready = 1'b1;
	assign reg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q  <= 1'b0;
			unique_only_q <= 1'b0;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_DESCENDING:  descending_q  <= pwdata[0];
				REG_UNIQUE_ONLY: unique_only_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DESCENDING:  rd_bit = descending_q;
			REG_UNIQUE_ONLY: rd_bit = unique_only_q;
			default:         rd_bit = 1'b0;
		endcase
	end

	assign prdata = {{(DATA_W-1){1'b0}}, rd_bit};

	sowd_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	sowd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_data  (front_cmd),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_data  (back_cmd)
	);

	sowd_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.descending   (descending_q),
		.unique_only  (unique_only_q),
		.cmd_valid    (back_valid),
		.cmd_ready    (back_ready),
		.cmd          (back_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### rtl/core/sowd_front.sv
// ----------------------------------------------------------------------------
// sowd_front
// Accepts items, tracks the fill count and overflow of the current set and
// turns each item into a command for the sorter.
// ----------------------------------------------------------------------------
module sowd_front #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sowd_pkg::in_item_t item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output sowd_pkg::cmd_t    cmd
);
	import sowd_pkg::*;

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             has_room;
	logic             xfer;

	assign has_room   = count_q < CNT_W'(MAX_ELEMENTS);
	assign item_ready = cmd_ready;
	assign cmd_valid  = item_valid;
	assign xfer       = item_valid & cmd_ready;

	assign cmd.value      = item.value;
	assign cmd.store      = has_room;
	assign cmd.last       = item.is_last;
	assign cmd.overflowed = overflow_q | ~has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (xfer) begin
			if (item.is_last) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (has_room) begin
				count_q <= count_q + 1'b1;
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

endmodule

### rtl/core/sowd_fifo.sv
// ----------------------------------------------------------------------------
// sowd_fifo
// Short command queue between front and back so that each can stall alone.
// ----------------------------------------------------------------------------
module sowd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  sowd_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output sowd_pkg::cmd_t rd_data
);
	import sowd_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign wr_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/sowd_back.sv
// ----------------------------------------------------------------------------
// sowd_back
// Insertion chain of sorting cells kept ascending from cell 0 upward, plus
// the drain sequencer with duplicate removal and the result register.
// ----------------------------------------------------------------------------
module sowd_back #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                descending,
	input  logic                unique_only,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  sowd_pkg::cmd_t      cmd,
	output logic                result_valid,
	input  logic                result_ready,
	output sowd_pkg::out_item_t result
);
	import sowd_pkg::*;

	localparam int TOP = MAX_ELEMENTS - 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ALIGN = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FLUSH = 4'b1000
	} back_state_t;

	back_state_t state_q;
	back_state_t state_d;

	value_t cell_val_q [MAX_ELEMENTS];
	logic   cell_vld_q [MAX_ELEMENTS];
	logic   gt         [MAX_ELEMENTS];
	logic   lo_gt      [MAX_ELEMENTS];
	logic   lo_vld     [MAX_ELEMENTS];
	logic   hi_vld     [MAX_ELEMENTS];
	value_t lo_val     [MAX_ELEMENTS];
	value_t hi_val     [MAX_ELEMENTS];

	value_t    pend_q;
	logic      have_pend_q;
	logic      set_ovf_q;
	out_item_t result_q;
	logic      result_valid_q;

	logic   pop;
	logic   do_insert;
	logic   do_shift_up;
	logic   do_shift_down;
	logic   drain_shift;
	logic   align_shift;
	logic   pend_load;
	logic   load_out;
	logic   out_end;
	logic   out_free;
	value_t src_val;
	logic   src_vld;

	assign cmd_ready    = state_q == ST_IDLE;
	assign pop          = cmd_valid & cmd_ready;
	assign do_insert    = pop & cmd.store;
	assign out_free     = ~result_valid_q | result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// drain end: top cell when descending, bottom cell otherwise
	assign src_val = descending ? cell_val_q[TOP] : cell_val_q[0];
	assign src_vld = descending ? cell_vld_q[TOP] : cell_vld_q[0];

	assign do_shift_up   = align_shift | (drain_shift & descending);
	assign do_shift_down = drain_shift & ~descending;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		// empty cells count as larger than any value
		assign gt[i] = ~cell_vld_q[i] | (cell_val_q[i] > cmd.value);

		if (i == 0) begin : g_bot
			assign lo_val[i] = '0;
			assign lo_vld[i] = 1'b0;
			assign lo_gt[i]  = 1'b0;
		end else begin : g_mid_lo
			assign lo_val[i] = cell_val_q[i-1];
			assign lo_vld[i] = cell_vld_q[i-1];
			assign lo_gt[i]  = gt[i-1];
		end

		if (i == TOP) begin : g_top
			assign hi_val[i] = '0;
			assign hi_vld[i] = 1'b0;
		end else begin : g_mid_hi
			assign hi_val[i] = cell_val_q[i+1];
			assign hi_vld[i] = cell_vld_q[i+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cell_vld_q[i] <= 1'b0;
			end else if (do_insert) begin
				cell_vld_q[i] <= cell_vld_q[i] | lo_vld[i] | (i == 0);
			end else if (do_shift_up) begin
				cell_vld_q[i] <= lo_vld[i];
			end else if (do_shift_down) begin
				cell_vld_q[i] <= hi_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (gt[i]) begin
					cell_val_q[i] <= lo_gt[i] ? lo_val[i] : cmd.value;
				end
			end else if (do_shift_up) begin
				cell_val_q[i] <= lo_val[i];
			end else if (do_shift_down) begin
				cell_val_q[i] <= hi_val[i];
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		align_shift = 1'b0;
		drain_shift = 1'b0;
		pend_load   = 1'b0;
		load_out    = 1'b0;
		out_end     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && cmd.last) begin
					state_d = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				// descending drain needs the largest element in the top cell
				if (descending && !cell_vld_q[TOP]) begin
					align_shift = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!src_vld) begin
					state_d = ST_FLUSH;
				end else if (!have_pend_q) begin
					pend_load   = 1'b1;
					drain_shift = 1'b1;
				end else if (unique_only && src_val == pend_q) begin
					drain_shift = 1'b1;
				end else if (out_free) begin
					load_out    = 1'b1;
					pend_load   = 1'b1;
					drain_shift = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					load_out = 1'b1;
					out_end  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			have_pend_q    <= 1'b0;
			set_ovf_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && cmd.last) begin
				set_ovf_q <= cmd.overflowed;
			end
			if (pend_load) begin
				have_pend_q <= 1'b1;
			end else if (out_end) begin
				have_pend_q <= 1'b0;
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// held back one element so the end mark lands on the last one emitted
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_q <= src_val;
		end
		if (load_out) begin
			result_q.sorted_value <= pend_q;
			result_q.end_of_set   <= out_end;
			result_q.overflowed   <= set_ovf_q;
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for sort_with_order_and_dedupe
// Feeds sets of values over the item channel and checks every sorted result
// against a predictor kept in a small scoreboard class. Covers ascending and
// descending order, repeat removal, value zero, overflow of the store, and
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import sowd_pkg::*;

	localparam int SET_CAPACITY   = 64;
	localparam int RANDOM_ITEMS   = 410;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = SET_CAPACITY + 16;

	typedef enum int {MIX_NARROW, MIX_FULL, MIX_EXTREME} value_mix_t;

	// predicts the sorted output of each set and checks results in order
	class sort_scoreboard;
		value_t    held[$];
		bit        lost;
		bit        desc_order;
		bit        drop_repeats;
		out_item_t awaited[$];
		int        errors;
		int        items;
		int        sets;
		int        results;
		int        overflow_sets;

		function void write_reg(logic idx, bit val);
			if (idx == REG_DESCENDING) begin
				desc_order = val;
			end else begin
				drop_repeats = val;
			end
		endfunction

		function void note_item(in_item_t it);
			value_t    ord[$];
			value_t    picked[$];
			value_t    key;
			value_t    e;
			out_item_t r;
			int        j;
			items++;
			if (held.size() < SET_CAPACITY) begin
				held.push_back(it.value);
			end else begin
				lost = 1'b1;
			end
			if (!it.is_last) return;
			ord = held;
			for (int i = 1; i < ord.size(); i++) begin
				key = ord[i];
				j = i;
				while (j > 0 && ord[j-1] > key) begin
					ord[j] = ord[j-1];
					j--;
				end
				ord[j] = key;
			end
			for (int k = 0; k < ord.size(); k++) begin
				e = desc_order ? ord[ord.size()-1-k] : ord[k];
				if (drop_repeats && picked.size() > 0 && picked[picked.size()-1] == e)
					continue;
				picked.push_back(e);
			end
			foreach (picked[i]) begin
				r.sorted_value = picked[i];
				r.end_of_set   = (i == picked.size() - 1);
				r.overflowed   = lost;
				awaited.push_back(r);
			end
			sets++;
			if (lost) overflow_sets++;
			held.delete();
			lost = 1'b0;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: sorted_value %0d", got.sorted_value);
				errors++;
				return;
			end
			want = awaited.pop_front();
			results++;
			if (got.sorted_value !== want.sorted_value) begin
				$error("sorted_value: expected %0d, got %0d", want.sorted_value,
					got.sorted_value);
				errors++;
			end
			if (got.end_of_set !== want.end_of_set) begin
				$error("end_of_set: expected %0b, got %0b", want.end_of_set, got.end_of_set);
				errors++;
			end
			if (got.overflowed !== want.overflowed) begin
				$error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	in_item_t            item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	out_item_t           result;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	sort_scoreboard tally = new();

	int  burst_left  = 0;
	bit  tx_steady   = 1'b0;
	bit  rx_free     = 1'b0;
	int  rx_left     = 0;
	int  idle_cycles = 0;
	int  phases      = 0;

	sort_with_order_and_dedupe #(
		.MAX_ELEMENTS(SET_CAPACITY)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: stretches of ready and stalls of random length
	always @(posedge clk) begin
		if (rx_left == 0) begin
			if (rx_free) begin
				result_ready <= 1'b1;
				rx_left <= 8;
			end else if ($urandom_range(0, 2) == 0) begin
				result_ready <= 1'b0;
				rx_left <= $urandom_range(1, 6);
			end else begin
				result_ready <= 1'b1;
				rx_left <= $urandom_range(1, 12);
			end
		end else begin
			rx_left <= rx_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tally.check_result(result);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic value_t pick_value(value_mix_t mix);
		value_t v;
		case (mix)
			MIX_NARROW: v = value_t'($urandom_range(0, 7));
			MIX_FULL: v = value_t'($urandom());
			default: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = 31'd1;
					2: v = 31'h7FFF_FFFF;
					default: v = 31'h7FFF_FFFE;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = tx_steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		tally.note_item(it);
	endtask

	task automatic send_list(input value_t vals[$]);
		in_item_t it;
		foreach (vals[i]) begin
			it.value   = vals[i];
			it.is_last = (i == vals.size() - 1);
			send_item(it);
		end
	endtask

	task automatic send_set(int n, value_mix_t mix);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.value   = pick_value(mix);
			it.is_last = (i == n - 1);
			send_item(it);
		end
	endtask

	// hold the sender until every result is back and the drain has settled
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (tally.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, bit val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom() & 32'hFFFF_FFFE) | DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tally.write_reg(idx, val);
	endtask

	task automatic configure(bit desc, bit uniq);
		wait_idle();
		apb_write(REG_DESCENDING, desc);
		apb_write(REG_UNIQUE_ONLY, uniq);
		psel    <= 1'b0;
		penable <= 1'b0;
		phases++;
	endtask

	initial begin
		value_t     vals[$];
		value_mix_t mix;
		int         first_random;
		int         p;
		int         n;
		int         nsets;
		bit         desc;
		bit         uniq;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets, reset order first: ascending, repeats kept
		vals = '{31'h7FFF_FFFF};
		send_list(vals);
		vals = '{31'd5, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'd5, 31'h4000_0000};
		send_list(vals);
		configure(1'b1, 1'b1);
		vals = '{31'd3, 31'd7, 31'd3, 31'h7FFF_FFFF, 31'd7, 31'd3};
		send_list(vals);
		vals = '{31'd9, 31'd9, 31'd9};
		send_list(vals);
		configure(1'b0, 1'b1);
		vals = '{31'd2, 31'd1, 31'd2, 31'd1, 31'd0, 31'd0};
		send_list(vals);
		configure(1'b1, 1'b0);
		vals = '{31'd4, 31'd4};
		send_list(vals);

		// random sets; a few fill the store exactly or run past it
		first_random = tally.items;
		p = 0;
		while (tally.items - first_random < RANDOM_ITEMS) begin
			if (p < 4) begin
				desc = p[0];
				uniq = p[1];
			end else begin
				desc = 1'($urandom_range(0, 1));
				uniq = 1'($urandom_range(0, 1));
			end
			tx_steady = (p % 5 == 2);
			rx_free <= (p % 5 == 3);
			configure(desc, uniq);
			nsets = $urandom_range(2, 5);
			for (int s = 0; s < nsets; s++) begin
				if ($urandom_range(0, 11) == 0)
					n = $urandom_range(SET_CAPACITY - 4, SET_CAPACITY + 8);
				else
					n = $urandom_range(1, 10);
				if (s == 0 && p == 1) n = SET_CAPACITY;
				if (s == 0 && p == 2) n = SET_CAPACITY + 1;
				if (s == 0 && p == 3) n = SET_CAPACITY + 6;
				case ($urandom_range(0, 4))
					0, 1: mix = MIX_NARROW;
					2, 3: mix = MIX_FULL;
					default: mix = MIX_EXTREME;
				endcase
				send_set(n, mix);
			end
			p++;
		end

		wait_idle();
		$display("covered %0d items in %0d sets (%0d with discarded items), %0d results checked",
			tally.items, tally.sets, tally.overflow_sets, tally.results);
		$display("both orders with and without repeat removal, %0d register phases", phases);
		if (tally.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/sowd_pkg.sv
rtl/core/sowd_front.sv
rtl/core/sowd_fifo.sv
rtl/core/sowd_back.sv
rtl/core/sort_with_order_and_dedupe.sv
dv/testbench.sv
